>>> rtl/kalman_fuse_2d_position_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D Kalman fusion unit
// Implication checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KALMAN_FUSE_2D_POSITION_UNIT_ASSERT_SVH
`define KALMAN_FUSE_2D_POSITION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define KF_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("kf2d assertion failed");
`define KF_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("kf2d assertion failed");
`else
`define KF_ASSERT_IMP(lbl, ck, rs, a, c)
`define KF_ASSERT_NXT(lbl, ck, rs, a, c)
`endif
`endif

>>> rtl/kf2d_pkg.sv
// ----------------------------------------------------------------------------
// kf2d_pkg
// Shared types, constants and helpers of the 2-D Kalman fusion unit.
// ----------------------------------------------------------------------------
`default_nettype none
package kf2d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W         = 66;   // holds an exact 32x32 difference of products
  localparam int DV_W          = 64;   // divider dividend width
  localparam int QB            = 33;   // quotient bits developed by the divider

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FUSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_ACC,
    ST_DET,
    ST_DIV,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic flip;   // numerator is negated
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sx32(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

>>> rtl/kf2d_mul.sv
// ----------------------------------------------------------------------------
// kf2d_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module kf2d_mul import kf2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);

  always_ff @(posedge clk) begin
    if (en) p <= a * b;
  end

endmodule
`default_nettype wire

>>> rtl/kf2d_div.sv
// ----------------------------------------------------------------------------
// kf2d_div
// Radix-2 restoring divider: round(num * 2^F / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module kf2d_div import kf2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire div_ctl_t                          ctl,
  input  wire logic signed [31:0]                num,
  input  wire logic signed [ACC_W-FRAC_BITS-1:0] den,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [31:0]                     q
);

  localparam int DET_W = ACC_W - FRAC_BITS;
  localparam int CNT_W = $clog2(QB + 1);

  logic [DET_W-1:0] ud;
  logic [DET_W-1:0] ud_in;
  logic [31:0]      un;
  logic [DV_W-1:0]  dvd;
  logic [DV_W-QB-1:0] hi;
  logic [DET_W-1:0] rem;
  logic [QB-1:0]    lo;
  logic [DET_W:0]   trial;
  logic             ge;
  logic             neg;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic [QB-1:0]    qc;
  logic [QB-1:0]    qs;

  always_comb begin
    ud_in = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
    un    = num[31] ? 32'(-num) : 32'(num);
    dvd   = (DV_W'(un) << FRAC_BITS) + DV_W'(ud_in >> 1);
    hi    = dvd[DV_W-1:QB];
    trial = {rem, lo[QB-1]};
    ge    = trial >= {1'b0, ud};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      ud  <= ud_in;
      neg <= (num[31] ^ ctl.flip) ^ den[DET_W-1];
      ovf <= DET_W'(hi) >= ud_in;
      rem <= DET_W'(hi);
      lo  <= dvd[QB-1:0];
    end else if (busy) begin
      rem <= ge ? DET_W'(trial - {1'b0, ud}) : trial[DET_W-1:0];
      lo  <= {lo[QB-2:0], ge};
    end
  end

  // clamp magnitude to 2^31, then fold to signed 32
  always_comb begin
    qc = (ovf || lo > (QB'(1) << 31)) ? (QB'(1) << 31) : lo;
    if (neg) qs = QB'(-qc);
    else if (qc == (QB'(1) << 31)) qs = (QB'(1) << 31) - 1'b1;
    else qs = qc;
  end

  // quotient is complete while done is high
  assign q = qs[31:0];

endmodule
`default_nettype wire

>>> rtl/kalman_fuse_2d_position_unit.sv
// ----------------------------------------------------------------------------
// kalman_fuse_2d_position_unit
// 2-D Kalman position fusion on one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: fields, tuser: op
// m_*      out  m_tvalid/m_tready  tdata: estimate, tuser: singular
//
// Load: a request goes straight to the output step. Fuse: a sum step, the det products,
// then four divisions (start, bit steps, hand-off) and the remaining products, for
// 22 multiply-accumulates on the one multiplier. A zero det skips to the output step.
// Ready only in idle; a held result stalls the finish step.
// Synchronous reset clears the estimate to zero and the handshake state.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_fuse_2d_position_unit import kf2d_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, var_xx, var_xy, var_yx, var_yy, zero pad
  input  wire logic [191:0] s_tdata,
  // op
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // est_x, est_y, est_xx, est_xy, est_yx, est_yy
  output logic [191:0]      m_tdata,
  // singular
  output logic [0:0]        m_tuser
);

  localparam int DET_W = ACC_W - FRAC_BITS;
  localparam logic [4:0] STEP_DET  = 5'd1;
  localparam logic [4:0] STEP_LAST = 5'd21;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(1) <<< FRAC_BITS;

  state_t state, state_next;

  logic signed [31:0] mean_x, mean_y;
  logic signed [31:0] cov [4];
  logic signed [31:0] zx, zy;
  logic signed [31:0] rc [4];
  logic signed [31:0] s [4];
  logic signed [31:0] inv [4];
  logic signed [31:0] k [4];
  logic signed [31:0] mn [2];
  logic signed [31:0] cn [4];
  logic signed [31:0] dx, dy;
  logic signed [DET_W-1:0] det;
  logic signed [ACC_W-1:0] acc;
  logic singular;
  logic [4:0] step;
  logic [1:0] div_idx;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [63:0] fm;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] det_full;
  logic [4:0] step_m2;
  logic [3:0] pair;
  logic       first;
  logic signed [31:0] am [4];
  logic signed [31:0] div_num;
  div_ctl_t div_ctl;
  logic div_busy, div_done;
  logic signed [31:0] div_q;
  logic accept;
  logic out_fire;

  logic signed [31:0] o_x, o_y, o_xx, o_xy, o_yx, o_yy;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_fire = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (state)
      ST_IDLE:     state_next = accept ? (s_tuser[0] == OP_FUSE ? ST_SUM : ST_OUT) : ST_IDLE;
      ST_SUM:      state_next = ST_MUL;
      ST_MUL:      state_next = ST_ACC;
      ST_ACC:      state_next = (step == STEP_DET) ? ST_DET
                              : (step == STEP_LAST) ? ST_OUT : ST_MUL;
      ST_DET:      state_next = (det_full == '0) ? ST_OUT : ST_DIV;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: state_next = !div_done ? ST_DIV_WAIT
                              : (div_idx == 2'd3) ? ST_MUL : ST_DIV;
      ST_OUT:      state_next = out_fire ? ST_IDLE : ST_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_ctl.start = (state == ST_DIV);
    div_ctl.flip  = (div_idx == 2'd1) || (div_idx == 2'd2);
    unique case (div_idx)
      2'd0:    div_num = s[3];
      2'd1:    div_num = s[1];
      2'd2:    div_num = s[2];
      default: div_num = s[0];
    endcase
  end

  // I - K
  always_comb begin
    am[0] = sat32(ONE_A - sx32(k[0]));
    am[1] = sat32(-sx32(k[1]));
    am[2] = sat32(-sx32(k[2]));
    am[3] = sat32(ONE_A - sx32(k[3]));
  end

  always_comb begin
    unique case (step)
      5'd0:    begin op_a = s[0];  op_b = s[3];   end
      5'd1:    begin op_a = s[1];  op_b = s[2];   end
      5'd2:    begin op_a = cov[0]; op_b = inv[0]; end
      5'd3:    begin op_a = cov[1]; op_b = inv[2]; end
      5'd4:    begin op_a = cov[0]; op_b = inv[1]; end
      5'd5:    begin op_a = cov[1]; op_b = inv[3]; end
      5'd6:    begin op_a = cov[2]; op_b = inv[0]; end
      5'd7:    begin op_a = cov[3]; op_b = inv[2]; end
      5'd8:    begin op_a = cov[2]; op_b = inv[1]; end
      5'd9:    begin op_a = cov[3]; op_b = inv[3]; end
      5'd10:   begin op_a = k[0];  op_b = dx;     end
      5'd11:   begin op_a = k[1];  op_b = dy;     end
      5'd12:   begin op_a = k[2];  op_b = dx;     end
      5'd13:   begin op_a = k[3];  op_b = dy;     end
      5'd14:   begin op_a = am[0]; op_b = cov[0]; end
      5'd15:   begin op_a = am[1]; op_b = cov[2]; end
      5'd16:   begin op_a = am[0]; op_b = cov[1]; end
      5'd17:   begin op_a = am[1]; op_b = cov[3]; end
      5'd18:   begin op_a = am[2]; op_b = cov[0]; end
      5'd19:   begin op_a = am[3]; op_b = cov[2]; end
      5'd20:   begin op_a = am[2]; op_b = cov[1]; end
      default: begin op_a = am[3]; op_b = cov[3]; end
    endcase
  end

  kf2d_mul u_mul (
    .clk (clk),
    .en  (state == ST_MUL),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  kf2d_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (det),
    .busy (div_busy),
    .done (div_done),
    .q    (div_q)
  );

  always_comb begin
    step_m2  = step - 5'd2;
    pair     = step_m2[4:1];
    first    = !step[0];
    fm       = (prod + HALF) >>> FRAC_BITS;
    base     = (pair == 4'd4) ? sx32(mean_x) : (pair == 4'd5) ? sx32(mean_y) : '0;
    sum      = (first ? base : acc) + ACC_W'(fm);
    det_full = (acc + HALF_A) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      mean_x   <= '0;
      mean_y   <= '0;
      for (int i = 0; i < 4; i++) cov[i] <= '0;
    end else begin
      state <= state_next;
      if (out_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (accept && s_tuser[0] == OP_LOAD) begin
        mean_x <= s_tdata[31:0];
        mean_y <= s_tdata[63:32];
        cov[0] <= {1'b0, s_tdata[94:64]};
        cov[1] <= s_tdata[126:95];
        cov[2] <= s_tdata[158:127];
        cov[3] <= {1'b0, s_tdata[189:159]};
      end else if (state == ST_ACC && step == STEP_LAST) begin
        mean_x <= mn[0];
        mean_y <= mn[1];
        cov[0] <= cn[0];
        cov[1] <= cn[1];
        cov[2] <= cn[2];
        cov[3] <= sat32(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      zx       <= s_tdata[31:0];
      zy       <= s_tdata[63:32];
      rc[0]    <= {1'b0, s_tdata[94:64]};
      rc[1]    <= s_tdata[126:95];
      rc[2]    <= s_tdata[158:127];
      rc[3]    <= {1'b0, s_tdata[189:159]};
      singular <= 1'b0;
    end
    if (state == ST_SUM) begin
      for (int i = 0; i < 4; i++) s[i] <= sat32(sx32(cov[i]) + sx32(rc[i]));
      dx   <= sat32(sx32(zx) - sx32(mean_x));
      dy   <= sat32(sx32(zy) - sx32(mean_y));
      step <= '0;
    end
    if (state == ST_ACC) begin
      if (step == 5'd0) acc <= ACC_W'(prod);
      else if (step == STEP_DET) acc <= acc - ACC_W'(prod);
      else begin
        acc <= sum;
        if (!first) begin
          unique case (pair)
            4'd0:    k[0]  <= sat32(sum);
            4'd1:    k[1]  <= sat32(sum);
            4'd2:    k[2]  <= sat32(sum);
            4'd3:    k[3]  <= sat32(sum);
            4'd4:    mn[0] <= sat32(sum);
            4'd5:    mn[1] <= sat32(sum);
            4'd6:    cn[0] <= sat32(sum);
            4'd7:    cn[1] <= sat32(sum);
            4'd8:    cn[2] <= sat32(sum);
            default: cn[3] <= sat32(sum);
          endcase
        end
      end
      if (step != STEP_LAST) step <= step + 5'd1;
    end
    if (state == ST_DET) begin
      det     <= det_full[DET_W-1:0];
      div_idx <= '0;
      if (det_full == '0) singular <= 1'b1;
    end
    if (state == ST_DIV_WAIT && div_done) begin
      inv[div_idx] <= div_q;
      div_idx      <= div_idx + 2'd1;
    end
    if (out_fire) begin
      o_x  <= mean_x;
      o_y  <= mean_y;
      o_xx <= cov[0];
      o_xy <= cov[1];
      o_yx <= cov[2];
      o_yy <= cov[3];
      m_tuser[0] <= singular;
    end
  end

  assign m_tdata = {o_yy, o_yx, o_xy, o_xx, o_y, o_x};

`include "kalman_fuse_2d_position_unit_assert.svh"

  `KF_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !s_tready)
  `KF_ASSERT_IMP(a_div_only_waiting, clk, rst, div_busy, state == ST_DIV_WAIT)
  `KF_ASSERT_IMP(a_done_when_waiting, clk, rst, div_done, state == ST_DIV_WAIT)
  `KF_ASSERT_IMP(a_sing_zero_det, clk, rst, state == ST_DIV, det != '0)

endmodule
`default_nettype wire

>>> dv/kalman_fuse_2d_position_unit_tb.sv
// ----------------------------------------------------------------------------
// kalman_fuse_2d_position_unit_tb
// Drives load and fuse requests through the stream ports. A directed table
// covers field extremes and the zero determinant, then random requests follow.
// Fixed-point Kalman model or typed row gives each estimate, checked per field.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_fuse_2d_position_unit_tb import kf2d_pkg::*; ();

  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 580;
  localparam int IDLE_LIMIT = 6000;

  typedef struct packed {
    logic [31:0] x, y, xx, xy, yx, yy;
    logic        sing;
  } est_t;

  typedef struct {
    logic        op;
    logic [31:0] x, y;
    logic [30:0] xx;
    logic [31:0] xy, yx;
    logic [30:0] yy;
    bit          typed;
    est_t        want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic [0:0]   m_tuser;

  kalman_fuse_2d_position_unit dut (.*);

  always #2 clk = ~clk;

  // ---------------- estimate model ----------------
  longint mdl_mx, mdl_my;
  longint mdl_p[4];
  est_t   est_q[$];
  int     errors = 0;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor((p + half lsb) / 2^FB)
  function automatic longint rnd_shift(input logic signed [127:0] p);
    logic signed [127:0] t;
    t = p + (128'sd1 <<< (FB - 1));
    return longint'(t >>> FB);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return rnd_shift(pa * pb);
  endfunction

  // nearest, ties away from zero
  function automatic longint qdiv(input longint n, input longint d);
    logic signed [127:0] num;
    logic [127:0] un, ud, q;
    bit neg;
    num = n;
    num = num <<< FB;
    neg = (num < 0) != (d < 0);
    un = (num < 0) ? -num : num;
    ud = (d < 0) ? -d : d;
    q = (un + ud / 2) / ud;
    if (q > 128'h80000000) q = 128'h80000000;
    return clip32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic void mat2_mul(output longint o[4], input longint a[4],
                                   input longint b[4]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        o[i*2+j] = clip32(qmul(a[i*2], b[j]) + qmul(a[i*2+1], b[2+j]));
  endfunction

  function automatic bit fuse_obs(input longint zx, input longint zy, input longint rc[4]);
    longint s[4], inv[4], k[4], a[4], np[4];
    longint dx, dy, one;
    logic signed [127:0] s0, s1, s2, s3;
    longint det;
    one = 64'sd1 <<< FB;
    for (int i = 0; i < 4; i++) s[i] = clip32(mdl_p[i] + rc[i]);
    s0 = s[0]; s1 = s[1]; s2 = s[2]; s3 = s[3];
    det = rnd_shift(s0 * s3 - s1 * s2);
    if (det == 0) return 1'b1;
    inv[0] = qdiv(s[3], det);
    inv[1] = qdiv(-s[1], det);
    inv[2] = qdiv(-s[2], det);
    inv[3] = qdiv(s[0], det);
    mat2_mul(k, mdl_p, inv);
    dx = clip32(zx - mdl_mx);
    dy = clip32(zy - mdl_my);
    mdl_mx = clip32(mdl_mx + qmul(k[0], dx) + qmul(k[1], dy));
    mdl_my = clip32(mdl_my + qmul(k[2], dx) + qmul(k[3], dy));
    a[0] = clip32(one - k[0]);
    a[1] = clip32(-k[1]);
    a[2] = clip32(-k[2]);
    a[3] = clip32(one - k[3]);
    mat2_mul(np, a, mdl_p);
    mdl_p = np;
    return 1'b0;
  endfunction

  function automatic est_t predict_est(input row_t r);
    longint rc[4];
    longint zx, zy;
    bit sing;
    est_t e;
    zx = longint'(signed'(r.x));
    zy = longint'(signed'(r.y));
    rc[0] = longint'({1'b0, r.xx});
    rc[1] = longint'(signed'(r.xy));
    rc[2] = longint'(signed'(r.yx));
    rc[3] = longint'({1'b0, r.yy});
    sing = 1'b0;
    if (r.op == OP_LOAD) begin
      mdl_mx = zx;
      mdl_my = zy;
      mdl_p = rc;
    end else begin
      sing = fuse_obs(zx, zy, rc);
    end
    e.x = mdl_mx[31:0];
    e.y = mdl_my[31:0];
    e.xx = mdl_p[0][31:0];
    e.xy = mdl_p[1][31:0];
    e.yx = mdl_p[2][31:0];
    e.yy = mdl_p[3][31:0];
    e.sing = sing;
    return e;
  endfunction

  // ---------------- sender ----------------
  int burst_left = 1;

  task automatic send_req(input row_t r);
    est_t p;
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.yy, r.yx, r.xy, r.xx, r.y, r.x};
    s_tuser <= r.op;
    do @(posedge clk); while (!s_tready);
    p = predict_est(r);
    est_q.push_back(r.typed ? r.want : p);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    endcase
  endfunction

  function automatic logic [30:0] rand_var();
    case ($urandom_range(0, 11))
      0: return 31'($urandom);
      1: return 31'h7fffffff;
      2: return 31'h0;
      default: return 31'($urandom_range(1, 32'h00040000));
    endcase
  endfunction

  function automatic logic [31:0] rand_cross();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      2: return 32'h0;
      default: return 32'(int'($urandom_range(0, 32'h0000ffff)) - 32'sh00008000);
    endcase
  endfunction

  // ---------------- directed table ----------------
  row_t dir_rows[] = '{
    // fuse on the reset state: P+R is zero
    '{OP_FUSE, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 31'h0, 1,
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
    '{OP_LOAD, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
      31'h0, 1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
      32'h7fffffff, 32'h0, 1'b0}},
    '{OP_LOAD, 32'h80000000, 32'h7fffffff, 31'h0, 32'h7fffffff, 32'h80000000,
      31'h7fffffff, 1, '{32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff,
      32'h80000000, 32'h7fffffff, 1'b0}},
    '{OP_FUSE, 32'hffffffff, 32'h0, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      31'h7fffffff, 0, '0},
    // rank-one covariance, zero noise: singular, estimate held
    '{OP_LOAD, 32'h10000, 32'h20000, 31'h10000, 32'h10000, 32'h10000, 31'h10000, 1,
      '{32'h10000, 32'h20000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 1'b0}},
    '{OP_FUSE, 32'h7fffffff, 32'h80000000, 31'h0, 32'h0, 32'h0, 31'h0, 1,
      '{32'h10000, 32'h20000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 1'b1}},
    // unit P, unit R: gain is one half
    '{OP_LOAD, 32'h0, 32'h0, 31'h10000, 32'h0, 32'h0, 31'h10000, 1,
      '{32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 1'b0}},
    '{OP_FUSE, 32'h20000, 32'hfffe0000, 31'h10000, 32'h0, 32'h0, 31'h10000, 1,
      '{32'h10000, 32'hffff0000, 32'h8000, 32'h0, 32'h0, 32'h8000, 1'b0}},
    '{OP_FUSE, 32'h7fffffff, 32'h80000000, 31'h1, 32'h0, 32'h0, 31'h1, 0, '0},
    '{OP_FUSE, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000,
      31'h7fffffff, 0, '0},
    '{OP_LOAD, 32'h12345, 32'hfffedcba, 31'h30000, 32'hffff8000, 32'h8000, 31'h20000,
      0, '0},
    '{OP_FUSE, 32'h54321, 32'h0, 31'h18000, 32'h4000, 32'hffffc000, 31'h28000, 0, '0},
    '{OP_FUSE, 32'hfff00000, 32'h00100000, 31'h1, 32'hffffffff, 32'h1, 31'h2, 0, '0},
    '{OP_LOAD, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa, 32'h55555555, 32'haaaaaaaa,
      31'h55555555, 0, '0},
    '{OP_FUSE, 32'h55555555, 32'haaaaaaaa, 31'h55555555, 32'haaaaaaaa, 32'h55555555,
      31'h2aaaaaaa, 0, '0}
  };

  initial begin
    row_t r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_req(dir_rows[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      r.op = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_FUSE;
      r.x = rand_coord();
      r.y = rand_coord();
      r.xx = rand_var();
      r.xy = rand_cross();
      r.yx = ($urandom_range(0, 2) != 0) ? r.xy : rand_cross();
      r.yy = rand_var();
      r.typed = 1'b0;
      r.want = '0;
      send_req(r);
    end
    s_tvalid <= 1'b0;
    while (est_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("kalman_fuse_2d_position_unit_tb: clean");
    else $display("kalman_fuse_2d_position_unit_tb: errors");
    $finish;
  end

  // ---------------- receiver ----------------
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case ((cyc / 500) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 5) == 0);
        default: m_tready <= (cyc % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    est_t got, w;
    if (!rst && m_tvalid && m_tready) begin
      got.x    = m_tdata[31:0];
      got.y    = m_tdata[63:32];
      got.xx   = m_tdata[95:64];
      got.xy   = m_tdata[127:96];
      got.yx   = m_tdata[159:128];
      got.yy   = m_tdata[191:160];
      got.sing = m_tuser[0];
      if (est_q.size() == 0) begin
        $error("estimate returned with no request pending");
        errors++;
      end else begin
        w = est_q.pop_front();
        if (got.x !== w.x) begin $error("est_x exp %h got %h", w.x, got.x); errors++; end
        if (got.y !== w.y) begin $error("est_y exp %h got %h", w.y, got.y); errors++; end
        if (got.xx !== w.xx) begin $error("est_xx exp %h got %h", w.xx, got.xx); errors++; end
        if (got.xy !== w.xy) begin $error("est_xy exp %h got %h", w.xy, got.xy); errors++; end
        if (got.yx !== w.yx) begin $error("est_yx exp %h got %h", w.yx, got.yx); errors++; end
        if (got.yy !== w.yy) begin $error("est_yy exp %h got %h", w.yy, got.yy); errors++; end
        if (got.sing !== w.sing) begin
          $error("singular exp %b got %b", w.sing, got.sing);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cyc = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("kalman_fuse_2d_position_unit_tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
`default_nettype wire
